// File: hw/rtl/efp_pkg.sv
// Shared types and constants for the edge filter and pooling stream.
// Used by every module of the block except efp_ram; depends on nothing.

package efp_pkg;

   // Default sizes of the row stores and row counter
   localparam int MAX_COLUMNS_DEF = 1024;
   localparam int MAX_ROWS_DEF    = 4096;

   // Configuration register widths, indexes and reset values
   localparam int FRAME_HEIGHT_W = 13;
   localparam int FRAME_WIDTH_W  = 11;
   localparam int CSR_DATA_W     = 13;
   localparam int CSR_INDEX_W    = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd1;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd480;
   localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd640;

   localparam int PIX_W       = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam logic [PIX_W-1:0] CLAMP_TOP = 8'd255;

   // One classified pixel with the neighbors its results need
   typedef struct packed {
      logic             edge_valid;
      logic             edge_last;
      logic             pool_valid;
      logic             pool_last;
      logic [PIX_W-1:0] left_top;    // column x-2, row y-2
      logic [PIX_W-1:0] left_mid;    // column x-2, row y-1
      logic [PIX_W-1:0] left_bot;    // column x-2, row y
      logic [PIX_W-1:0] prev_mid;    // column x-1, row y-1
      logic [PIX_W-1:0] prev_bot;    // column x-1, row y
      logic [PIX_W-1:0] cur_top;     // column x, row y-2
      logic [PIX_W-1:0] cur_mid;     // column x, row y-1
      logic [PIX_W-1:0] cur_bot;     // column x, row y
   } item_type;

   // Queue status seen by the front and the back
   typedef struct packed {
      logic full;
      logic nonempty;
   } queue_status_type;

endpackage

// File: hw/rtl/efp_ram.sv
// Generic single-write, single-read RAM with registered, read-first output.
// Depends on nothing.

module efp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read; a read at the written address returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/efp_front.sv
// Front end: accepts pixels, keeps the frame position, the row stores and
// the six-pixel window, and pushes classified pixels into the queue.
// Depends on efp_pkg and efp_ram.

module efp_front #(
   parameter int MAX_COLUMNS = efp_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = efp_pkg::MAX_ROWS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [efp_pkg::PIX_W-1:0]           req_pixel,
   input  logic [efp_pkg::FRAME_HEIGHT_W-1:0]  frame_height,
   input  logic [efp_pkg::FRAME_WIDTH_W-1:0]   frame_width,
   input  efp_pkg::queue_status_type           queue_status,
   output logic                                push,
   output efp_pkg::item_type                   push_item
);

   localparam int COL_W = $clog2(MAX_COLUMNS);
   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int PW    = efp_pkg::PIX_W;

   // Effective frame size and the positions that end rows and frames
   logic [ROW_W:0]   h_eff;
   logic [COL_W:0]   w_eff;
   logic [ROW_W-1:0] last_row, pool_last_row;
   logic [COL_W-1:0] last_col, pool_last_col;

   always_comb begin
      if (32'(frame_height) > MAX_ROWS) begin
         h_eff = (ROW_W+1)'(MAX_ROWS);
      end else if (frame_height < efp_pkg::FRAME_HEIGHT_W'(2)) begin
         h_eff = (ROW_W+1)'(2);
      end else begin
         h_eff = (ROW_W+1)'(32'(frame_height));
      end
      if (32'(frame_width) > MAX_COLUMNS) begin
         w_eff = (COL_W+1)'(MAX_COLUMNS);
      end else if (frame_width < efp_pkg::FRAME_WIDTH_W'(2)) begin
         w_eff = (COL_W+1)'(2);
      end else begin
         w_eff = (COL_W+1)'(32'(frame_width));
      end
      last_row      = ROW_W'(h_eff - (ROW_W+1)'(1));
      last_col      = COL_W'(w_eff - (COL_W+1)'(1));
      pool_last_row = ROW_W'({h_eff[ROW_W:1], 1'b0} - (ROW_W+1)'(1));
      pool_last_col = COL_W'({w_eff[COL_W:1], 1'b0} - (COL_W+1)'(1));
   end

   // Position counters and the first stage, which waits for the row stores
   logic [COL_W-1:0] x_ff, x_in;
   logic [ROW_W-1:0] y_ff, y_in;
   logic             s1_valid_ff, s1_valid_in;
   logic [PW-1:0]    s1_pix_ff;
   logic [COL_W-1:0] s1_x_ff;
   logic             s1_edge_ff, s1_edge_last_ff, s1_pool_ff, s1_pool_last_ff;
   logic             accept, s1_adv, s1_result;

   // Window: columns x-2 and x-1, rows y-2 .. y
   logic [PW-1:0] win_ff [6];

   logic [2*PW-1:0] rd_rows;
   logic [PW-1:0]   above, two_above;

   assign above     = rd_rows[PW-1:0];
   assign two_above = rd_rows[2*PW-1:PW];

   assign s1_result = s1_edge_ff | s1_pool_ff;
   assign s1_adv    = s1_valid_ff & (~s1_result | ~queue_status.full);
   assign req_ready = ~s1_valid_ff | s1_adv;
   assign accept    = req_valid & req_ready;

   // Advance column, then row, wrapping at frame end
   always_comb begin
      x_in        = x_ff;
      y_in        = y_ff;
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         if (x_ff >= last_col) begin
            x_in = '0;
            y_in = (y_ff >= last_row) ? '0 : y_ff + ROW_W'(1);
         end else begin
            x_in = x_ff + COL_W'(1);
         end
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff        <= '0;
         y_ff        <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         x_ff        <= x_in;
         y_ff        <= y_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Classify the request on entry
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff       <= req_pixel;
         s1_x_ff         <= x_ff;
         s1_edge_ff      <= (|y_ff[ROW_W-1:1]) & (|x_ff[COL_W-1:1]);
         s1_edge_last_ff <= (y_ff == last_row) & (x_ff == last_col);
         s1_pool_ff      <= y_ff[0] & x_ff[0];
         s1_pool_last_ff <= (y_ff == pool_last_row) & (x_ff == pool_last_col);
      end
   end

   // Row stores: above in the low byte, two above in the high byte
   efp_ram #(
      .WIDTH (2*PW),
      .DEPTH (MAX_COLUMNS)
   ) u_rows (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_x_ff),
      .wr_data ({above, s1_pix_ff}),
      .rd_en   (accept),
      .rd_addr (x_ff),
      .rd_data (rd_rows)
   );

   // Shift the window as each pixel leaves the first stage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_adv) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= two_above;
         win_ff[4] <= above;
         win_ff[5] <= s1_pix_ff;
      end
   end

   // Push only pixels that produce a result
   assign push = s1_adv & s1_result;

   always_comb begin
      push_item.edge_valid = s1_edge_ff;
      push_item.edge_last  = s1_edge_last_ff;
      push_item.pool_valid = s1_pool_ff;
      push_item.pool_last  = s1_pool_last_ff;
      push_item.left_top   = win_ff[0];
      push_item.left_mid   = win_ff[1];
      push_item.left_bot   = win_ff[2];
      push_item.prev_mid   = win_ff[4];
      push_item.prev_bot   = win_ff[5];
      push_item.cur_top    = two_above;
      push_item.cur_mid    = above;
      push_item.cur_bot    = s1_pix_ff;
   end

endmodule

// File: hw/rtl/efp_queue.sv
// Short register queue between the front and back ends.
// Depends on efp_pkg.

module efp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  efp_pkg::item_type         push_item,
   input  logic                      pop,
   output efp_pkg::item_type         head_item,
   output efp_pkg::queue_status_type status
);

   localparam int DEPTH = efp_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   efp_pkg::item_type slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // Advance pointers with wrap and track fill
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == DEPTH - 1) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push & ~pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop & ~push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold pushed items
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item       = slot_ff[rd_ptr_ff];
   assign status.full     = (32'(count_ff) == DEPTH);
   assign status.nonempty = (count_ff != '0);

endmodule

// File: hw/rtl/efp_back.sv
// Back end: computes the clamped edge value and the 2x2 pooling results
// from the queue head and holds them in the output register.
// Depends on efp_pkg.

module efp_back (
   input  logic                            clock,
   input  logic                            reset,
   input  efp_pkg::item_type               head_item,
   input  efp_pkg::queue_status_type       queue_status,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,
   output logic                            rsp_tlast,
   output logic [2:0]                      rsp_tuser
);

   localparam int PW = efp_pkg::PIX_W;

   logic [PW+1:0] left_sum, right_sum, diff, pool_sum;
   logic [PW-1:0] edge_val, max_ab, max_cd, min_ab, min_cd, blk_max, blk_min;
   logic [PW-1:0] edge_out, max_out, min_out, mean_out;

   // Edge: left column minus right column, clamped to the pixel range
   always_comb begin
      left_sum  = (PW+2)'(head_item.left_top) + (PW+2)'(head_item.left_mid)
                + (PW+2)'(head_item.left_bot);
      right_sum = (PW+2)'(head_item.cur_top) + (PW+2)'(head_item.cur_mid)
                + (PW+2)'(head_item.cur_bot);
      diff      = left_sum - right_sum;
      if (left_sum <= right_sum) begin
         edge_val = '0;
      end else if (diff > (PW+2)'(efp_pkg::CLAMP_TOP)) begin
         edge_val = efp_pkg::CLAMP_TOP;
      end else begin
         edge_val = diff[PW-1:0];
      end
   end

   // Pooling over the 2x2 block ending at the current pixel
   always_comb begin
      max_ab   = (head_item.prev_mid > head_item.cur_mid) ? head_item.prev_mid
                                                          : head_item.cur_mid;
      max_cd   = (head_item.prev_bot > head_item.cur_bot) ? head_item.prev_bot
                                                          : head_item.cur_bot;
      min_ab   = (head_item.prev_mid < head_item.cur_mid) ? head_item.prev_mid
                                                          : head_item.cur_mid;
      min_cd   = (head_item.prev_bot < head_item.cur_bot) ? head_item.prev_bot
                                                          : head_item.cur_bot;
      blk_max  = (max_ab > max_cd) ? max_ab : max_cd;
      blk_min  = (min_ab < min_cd) ? min_ab : min_cd;
      pool_sum = (PW+2)'(head_item.prev_mid) + (PW+2)'(head_item.cur_mid)
               + (PW+2)'(head_item.prev_bot) + (PW+2)'(head_item.cur_bot);
   end

   // Zero fields of a part that carries no result
   assign edge_out = head_item.edge_valid ? edge_val : '0;
   assign max_out  = head_item.pool_valid ? blk_max : '0;
   assign min_out  = head_item.pool_valid ? blk_min : '0;
   assign mean_out = head_item.pool_valid ? pool_sum[PW+1:2] : '0;

   // Output register: load from the queue when empty or being drained
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;
   logic        rsp_last_ff;
   logic [2:0]  rsp_user_ff;

   assign pop = queue_status.nonempty & (~rsp_valid_ff | rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= {mean_out, min_out, max_out, edge_out};
         rsp_last_ff <= head_item.edge_valid & head_item.edge_last;
         rsp_user_ff <= {head_item.pool_valid & head_item.pool_last,
                         head_item.pool_valid, head_item.edge_valid};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// File: hw/rtl/edge_filter_and_pooling_stream.sv
// Top level of the 3x3 vertical-edge filter and 2x2 pooling stream.
// Holds the frame size registers; depends on efp_pkg, efp_front, efp_queue, efp_back.
//
//   channel   direction  handshake           payload
//   req_      in         tvalid / tready     tdata[7:0] pixel_value
//   rsp_      out        tvalid / tready     tdata, tlast, tuser (see ports)
//   csr_      in         valid / ready       index 0 frame_height, 1 frame_width
//
// One pixel is accepted per cycle while the queue is not full; each result passes
// through the first front stage, a queue slot and the output register. The row store
// word is registered in the first front stage and written back as its pixel leaves.
// Reset clears counters, window and queue; the row stores hold no reset value.
// A full queue stalls only the front; output stalls hold the back and fill the queue.

module edge_filter_and_pooling_stream #(
   parameter int MAX_COLUMNS = efp_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = efp_pkg::MAX_ROWS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Pixel requests
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // [7:0] pixel_value
   // Results
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [31:0]                        rsp_tdata,   // [7:0] edge_value,
                                                           // [15:8] block_max,
                                                           // [23:16] block_min,
                                                           // [31:24] block_mean
   output logic                               rsp_tlast,   // edge_last
   output logic [2:0]                         rsp_tuser,   // [0] edge_valid,
                                                           // [1] pool_valid,
                                                           // [2] pool_last
   // Register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [efp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [efp_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic [efp_pkg::FRAME_HEIGHT_W-1:0] frame_height_ff;
   logic [efp_pkg::FRAME_WIDTH_W-1:0]  frame_width_ff;

   // Take register writes at any time
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_height_ff <= efp_pkg::FRAME_HEIGHT_RST;
         frame_width_ff  <= efp_pkg::FRAME_WIDTH_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            efp_pkg::REG_FRAME_HEIGHT: begin
               frame_height_ff <= csr_data[efp_pkg::FRAME_HEIGHT_W-1:0];
            end
            efp_pkg::REG_FRAME_WIDTH: begin
               frame_width_ff <= csr_data[efp_pkg::FRAME_WIDTH_W-1:0];
            end
            default: begin
               frame_height_ff <= frame_height_ff;
            end
         endcase
      end
   end

   logic                      push, pop;
   efp_pkg::item_type         push_item, head_item;
   efp_pkg::queue_status_type queue_status;

   efp_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_pixel    (req_tdata),
      .frame_height (frame_height_ff),
      .frame_width  (frame_width_ff),
      .queue_status (queue_status),
      .push         (push),
      .push_item    (push_item)
   );

   efp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (queue_status)
   );

   efp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_item    (head_item),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .rsp_tuser    (rsp_tuser)
   );

endmodule
